>>> rtl/ihtc_pkg.sv
// ihtc_pkg: shared types and constants of the incubator heater and turner control unit
// no dependencies
`default_nettype none

package ihtc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_TURN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_ADJUST = 2'd2,
    CMD_STATUS = 2'd3
  } command_t;

  localparam logic [1:0] DIR_OFF   = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  localparam logic [2:0] REG_MAX_TEMP      = 3'd0;
  localparam logic [2:0] REG_MIN_TEMP      = 3'd1;
  localparam logic [2:0] REG_TURN_ON       = 3'd2;
  localparam logic [2:0] REG_TURN_PERIOD   = 3'd3;
  localparam logic [2:0] REG_TICKS_PER_SEC = 3'd4;
  localparam logic [2:0] REG_DEADTIME      = 3'd5;

  localparam int unsigned SEC_W    = 32;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned TEMP_W   = 10;
  localparam int unsigned TICK_W   = 5;
  localparam int unsigned DEAD_W   = 16;
  localparam int unsigned CFG_W    = 24;

  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 24'd3600;
  localparam logic [SEC_W-1:0]    SECONDS_MAX    = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

>>> rtl/incubator_heater_and_turner_control_unit.sv
// incubator_heater_and_turner_control_unit: heater hysteresis, seconds prescaler and turner
// uses ihtc_pkg; the turner remainder comes from a one-bit-per-cycle restoring divider
// Ticks, adjustments and status pass EXEC, then DONE, which loads the output register.
// Samples add DIV and TURN: the 25-bit compare/subtract runs 32 divider steps.
// One item at a time; the next item is taken while a finished beat waits at the output.
// Reset (rst, synchronous) restores register defaults and clears all control state.
`default_nettype none

module incubator_heater_and_turner_control_unit
  import ihtc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [TEMP_W-1:0]  sample,
  input  wire logic signed [23:0] clock_offset,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    heater_on,
  output logic                    motor_left,
  output logic                    motor_right,
  output logic [SEC_W-1:0]        elapsed_seconds,
  output logic [1:0]              turn_direction
);

  // configuration
  logic [TEMP_W-1:0]   max_temp;
  logic [TEMP_W-1:0]   min_temp;
  logic [PERIOD_W-1:0] turn_on_seconds;
  logic [PERIOD_W-1:0] turn_period_seconds;
  logic [TICK_W-1:0]   ticks_per_second;
  logic [DEAD_W-1:0]   deadtime_ticks;

  // control state
  state_t state, state_next;
  logic [TICK_W-1:0] tick_count;
  logic [SEC_W-1:0]  seconds_count;
  logic              heater_flag;
  logic [1:0]        last_direction;
  logic [DEAD_W-1:0] deadtime_left;

  // captured beat
  command_t          cmd_reg;
  logic [TEMP_W-1:0] sample_reg;
  logic [23:0]       offset_reg;

  // divider
  logic [SEC_W-1:0]    div_dividend;
  logic [PERIOD_W-1:0] div_rem;
  logic                div_q0;
  logic [4:0]          div_count;

  logic                accept;
  logic                out_load;
  logic [PERIOD_W-1:0] period_sel;
  logic [PERIOD_W:0]   div_shifted;
  logic [PERIOD_W+1:0] div_diff;
  logic                div_ge;
  logic [TICK_W-1:0]   tick_limit;
  logic [TICK_W:0]     tick_inc;
  logic [TICK_W:0]     tick_new;
  logic [33:0]         adj_sum;
  logic [1:0]          dir_new;
  logic                run;

  assign accept     = in_valid && !in_stall;
  assign period_sel = (turn_period_seconds == '0) ? DEFAULT_PERIOD : turn_period_seconds;

  assign div_shifted = {div_rem, div_dividend[SEC_W-1]};
  assign div_diff    = {1'b0, div_shifted} - {2'b00, period_sel};
  assign div_ge      = !div_diff[PERIOD_W+1];

  assign tick_limit = (ticks_per_second == '0) ? TICK_W'(1) : ticks_per_second;
  assign tick_inc   = {1'b0, tick_count} + (TICK_W+1)'(1);
  assign tick_new   = (tick_inc > {1'b0, tick_limit}) ? (tick_inc - {1'b0, tick_limit})
                                                     : tick_inc;

  assign adj_sum = {2'b00, seconds_count} + {{10{offset_reg[23]}}, offset_reg};

  assign dir_new = (div_rem < turn_on_seconds) ? (div_q0 ? DIR_LEFT : DIR_RIGHT) : DIR_OFF;
  assign run     = (deadtime_left == '0);

  always_ff @(posedge clk) begin
    state <= rst ? ST_IDLE : state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = (cmd_reg == CMD_SAMPLE) ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_count == 5'd31) begin
          state_next = ST_TURN;
        end
      end
      ST_TURN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_temp            <= TEMP_W'(75);
      min_temp            <= TEMP_W'(73);
      turn_on_seconds     <= PERIOD_W'(30);
      turn_period_seconds <= PERIOD_W'(60);
      ticks_per_second    <= TICK_W'(18);
      deadtime_ticks      <= DEAD_W'(18);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_TEMP:      max_temp            <= cfg_data[TEMP_W-1:0];
        REG_MIN_TEMP:      min_temp            <= cfg_data[TEMP_W-1:0];
        REG_TURN_ON:       turn_on_seconds     <= cfg_data[PERIOD_W-1:0];
        REG_TURN_PERIOD:   turn_period_seconds <= cfg_data[PERIOD_W-1:0];
        REG_TICKS_PER_SEC: ticks_per_second    <= cfg_data[TICK_W-1:0];
        REG_DEADTIME:      deadtime_ticks      <= cfg_data[DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg    <= command_t'(command);
      sample_reg <= sample;
      offset_reg <= clock_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      seconds_count  <= '0;
      heater_flag    <= 1'b0;
      last_direction <= DIR_OFF;
      deadtime_left  <= '0;
      div_count      <= '0;
    end else begin
      case (state)
        ST_EXEC: begin
          case (cmd_reg)
            CMD_TICK: begin
              tick_count <= tick_new[TICK_W-1:0];
              if (tick_inc > {1'b0, tick_limit} && seconds_count != SECONDS_MAX) begin
                seconds_count <= seconds_count + SEC_W'(1);
              end
              if (deadtime_left != '0) begin
                deadtime_left <= deadtime_left - DEAD_W'(1);
              end
            end
            CMD_SAMPLE: begin
              if (sample_reg > max_temp) begin
                heater_flag <= 1'b0;
              end else if (sample_reg < min_temp) begin
                heater_flag <= 1'b1;
              end
              div_count <= '0;
            end
            CMD_ADJUST: begin
              if (adj_sum[33]) begin
                seconds_count <= '0;
              end else if (adj_sum[32]) begin
                seconds_count <= SECONDS_MAX;
              end else begin
                seconds_count <= adj_sum[SEC_W-1:0];
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          div_count <= div_count + 5'd1;
        end
        ST_TURN: begin
          if (dir_new != last_direction) begin
            deadtime_left <= deadtime_ticks;
          end
          last_direction <= dir_new;
        end
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      div_dividend <= seconds_count;
      div_rem      <= '0;
      div_q0       <= 1'b0;
    end else if (state == ST_DIV) begin
      div_dividend <= {div_dividend[SEC_W-2:0], 1'b0};
      div_rem      <= div_ge ? div_diff[PERIOD_W-1:0] : div_shifted[PERIOD_W-1:0];
      div_q0       <= div_ge;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      heater_on       <= heater_flag;
      motor_left      <= run && (last_direction == DIR_LEFT);
      motor_right     <= run && (last_direction == DIR_RIGHT);
      elapsed_seconds <= seconds_count;
      turn_direction  <= last_direction;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC) && in_stall)
    else $error("accepted beat did not start execution");

  a_drain_when_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (state != ST_DONE) |=> !out_valid)
    else $error("taken output beat was not cleared");

  a_motor_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(motor_left && motor_right))
    else $error("both motor drives active");

  a_rem_below_period: assert property (@(posedge clk) disable iff (rst)
    state == ST_TURN |-> div_rem < period_sel)
    else $error("divider remainder not below period");
`endif

endmodule

`default_nettype wire

>>> dv/tb_incubator_heater_and_turner_control_unit.sv
// tb_incubator_heater_and_turner_control_unit: self-checking bench for the heater and turner unit
// a scoreboard class predicts every status beat; plain tasks drive commands and register writes
// depends on ihtc_pkg and incubator_heater_and_turner_control_unit
`timescale 1ns / 1ps

module tb_incubator_heater_and_turner_control_unit
  import ihtc_pkg::*;
();

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned END_CYCLES  = 40;

  typedef struct packed {
    logic             heater;
    logic             left;
    logic             right;
    logic [SEC_W-1:0] seconds;
    logic [1:0]       direction;
  } status_beat_t;

  class turner_scoreboard;
    logic [TEMP_W-1:0]   max_temp;
    logic [TEMP_W-1:0]   min_temp;
    logic [PERIOD_W-1:0] turn_on;
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   tps;
    logic [DEAD_W-1:0]   dead_ticks;
    logic [TICK_W-1:0]   prescale;
    logic [SEC_W-1:0]    seconds;
    logic                heater;
    logic [1:0]          direction;
    logic [DEAD_W-1:0]   dead_left;
    status_beat_t        status_q[$];
    int                  errors;
    int                  checked;
    int                  cmd_count[4];
    int                  top_hits;

    function new();
      max_temp   = 10'd75;
      min_temp   = 10'd73;
      turn_on    = 24'd30;
      period     = 24'd60;
      tps        = 5'd18;
      dead_ticks = 16'd18;
      prescale   = '0;
      seconds    = '0;
      heater     = 1'b0;
      direction  = DIR_OFF;
      dead_left  = '0;
      errors     = 0;
      checked    = 0;
      top_hits   = 0;
      cmd_count  = '{0, 0, 0, 0};
    endfunction

    function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MAX_TEMP:      max_temp = data[TEMP_W-1:0];
        REG_MIN_TEMP:      min_temp = data[TEMP_W-1:0];
        REG_TURN_ON:       turn_on = data[PERIOD_W-1:0];
        REG_TURN_PERIOD:   period = data[PERIOD_W-1:0];
        REG_TICKS_PER_SEC: tps = data[TICK_W-1:0];
        REG_DEADTIME:      dead_ticks = data[DEAD_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the predicted state by one accepted command and queue its status
    function void note_beat(command_t cmd, logic [TEMP_W-1:0] smp, logic signed [23:0] offset);
      logic [5:0]       limit;
      logic [5:0]       count;
      logic [SEC_W-1:0] span;
      logic [SEC_W-1:0] quotient;
      logic [1:0]       next_dir;
      longint           base;
      longint           delta;
      longint           adjusted;
      status_beat_t     beat;
      case (cmd)
        CMD_TICK: begin
          limit = (tps == '0) ? 6'd1 : {1'b0, tps};
          count = {1'b0, prescale} + 6'd1;
          if (count > limit) begin
            count = count - limit;
            if (seconds != SECONDS_MAX) seconds = seconds + 1'b1;
          end
          prescale = count[TICK_W-1:0];
          if (dead_left != '0) dead_left = dead_left - 1'b1;
        end
        CMD_SAMPLE: begin
          if (smp > max_temp) heater = 1'b0;
          else if (smp < min_temp) heater = 1'b1;
          span = (period == '0) ? {8'd0, DEFAULT_PERIOD} : {8'd0, period};
          quotient = seconds / span;
          if ((seconds % span) < {8'd0, turn_on}) begin
            next_dir = quotient[0] ? DIR_LEFT : DIR_RIGHT;
          end else begin
            next_dir = DIR_OFF;
          end
          if (next_dir != direction) dead_left = dead_ticks;
          direction = next_dir;
        end
        CMD_ADJUST: begin
          base = longint'(seconds);
          delta = longint'(offset);
          adjusted = base + delta;
          if (adjusted < 0) adjusted = 0;
          else if (adjusted > 64'sh0_FFFF_FFFF) adjusted = 64'sh0_FFFF_FFFF;
          seconds = adjusted[SEC_W-1:0];
        end
        default: ;
      endcase
      cmd_count[cmd]++;
      if (seconds == SECONDS_MAX) top_hits++;
      beat.heater    = heater;
      beat.left      = (dead_left == '0) && (direction == DIR_LEFT);
      beat.right     = (dead_left == '0) && (direction == DIR_RIGHT);
      beat.seconds   = seconds;
      beat.direction = direction;
      status_q.push_back(beat);
    endfunction

    function void match(string field, logic [SEC_W-1:0] want, logic [SEC_W-1:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(status_beat_t got);
      status_beat_t want;
      if (status_q.size() == 0) begin
        $error("status beat arrived with no command outstanding");
        errors++;
        return;
      end
      want = status_q.pop_front();
      checked++;
      match("heater_on", SEC_W'(want.heater), SEC_W'(got.heater));
      match("motor_left", SEC_W'(want.left), SEC_W'(got.left));
      match("motor_right", SEC_W'(want.right), SEC_W'(got.right));
      match("elapsed_seconds", want.seconds, got.seconds);
      match("turn_direction", SEC_W'(want.direction), SEC_W'(got.direction));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = REG_MAX_TEMP;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = CMD_STATUS;
  logic [TEMP_W-1:0]  sample = '0;
  logic signed [23:0] clock_offset = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               heater_on;
  logic               motor_left;
  logic               motor_right;
  logic [SEC_W-1:0]   elapsed_seconds;
  logic [1:0]         turn_direction;

  turner_scoreboard sb = new();
  bit               calm = 1'b0;
  bit               hold_request = 1'b0;
  int               settings = 0;

  always #4 clk = ~clk;

  incubator_heater_and_turner_control_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .sample          (sample),
    .clock_offset    (clock_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .heater_on       (heater_on),
    .motor_left      (motor_left),
    .motor_right     (motor_right),
    .elapsed_seconds (elapsed_seconds),
    .turn_direction  (turn_direction)
  );

  task automatic send_beat(command_t cmd, logic [TEMP_W-1:0] smp, logic signed [23:0] offset);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    sample       <= smp;
    clock_offset <= offset;
    do @(posedge clk); while (in_stall);
    sb.note_beat(cmd, smp, offset);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (sb.status_q.size() != 0);
  endtask

  task automatic program_regs(logic [TEMP_W-1:0] mx, logic [TEMP_W-1:0] mn,
                              logic [PERIOD_W-1:0] on_s, logic [PERIOD_W-1:0] per,
                              logic [TICK_W-1:0] tk, logic [DEAD_W-1:0] dead);
    logic [2:0]       idx[6];
    logic [CFG_W-1:0] vals[6];
    idx  = '{REG_MAX_TEMP, REG_MIN_TEMP, REG_TURN_ON, REG_TURN_PERIOD,
             REG_TICKS_PER_SEC, REG_DEADTIME};
    vals = '{{14'd0, mx}, {14'd0, mn}, on_s, per, {19'd0, tk}, {8'd0, dead}};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_write <= 1'b0;
    settings++;
  endtask

  task automatic program_random();
    program_regs(TEMP_W'($urandom), TEMP_W'($urandom),
                 ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12)),
                 24'($urandom_range(0, 15)), 5'($urandom_range(0, 30)),
                 16'($urandom_range(0, 6)));
  endtask

  // mix of commands; samples cluster around the hysteresis thresholds
  task automatic send_random(int n, int unsigned span);
    int unsigned      pick;
    int unsigned      raw;
    logic [TEMP_W-1:0] smp;
    logic [23:0]      offset;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      raw = $urandom_range(0, 1) ? {22'd0, sb.max_temp} : {22'd0, sb.min_temp};
      raw = ($urandom_range(0, 5) == 0) ? $urandom : raw + $urandom_range(0, 4) - 2;
      smp = raw[TEMP_W-1:0];
      raw = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2 * span) - span;
      offset = raw[23:0];
      if (pick < 45) send_beat(CMD_TICK, smp, offset);
      else if (pick < 75) send_beat(CMD_SAMPLE, smp, offset);
      else if (pick < 90) send_beat(CMD_ADJUST, smp, offset);
      else send_beat(CMD_STATUS, smp, offset);
    end
  endtask

  // result side: check accepted beats and stall in bursts
  initial begin
    status_beat_t got;
    int           stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.heater    = heater_on;
        got.left      = motor_left;
        got.right     = motor_right;
        got.seconds   = elapsed_seconds;
        got.direction = turn_direction;
        sb.check_beat(got);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_request) begin
        stall_left = LONG_HOLD;
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("[incubator_heater_and_turner_control_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: hysteresis edges, offset extremes, period boundaries
    send_beat(CMD_STATUS, 10'd0, 24'sd0);
    send_beat(CMD_SAMPLE, 10'd74, 24'sd0);
    send_beat(CMD_SAMPLE, 10'd72, 24'sd0);
    send_beat(CMD_SAMPLE, 10'd73, 24'sd0);
    send_beat(CMD_SAMPLE, 10'd75, 24'sd0);
    send_beat(CMD_SAMPLE, 10'd76, 24'sd0);
    send_beat(CMD_SAMPLE, 10'd0, 24'sd0);
    send_beat(CMD_SAMPLE, 10'd1023, 24'sd0);
    send_beat(CMD_SAMPLE, 10'd72, 24'sd0);
    repeat (3) send_beat(CMD_TICK, 10'd1023, 24'sh7F_FFFF);
    send_beat(CMD_ADJUST, 10'd0, 24'sh7F_FFFF);
    send_beat(CMD_ADJUST, 10'd0, 24'sh80_0000);
    send_beat(CMD_ADJUST, 10'd0, 24'sd59);
    send_beat(CMD_SAMPLE, 10'd74, 24'sd0);
    send_beat(CMD_ADJUST, 10'd0, 24'sd1);
    send_beat(CMD_SAMPLE, 10'd74, 24'sd0);
    send_beat(CMD_ADJUST, 10'd0, 24'sd60);
    send_beat(CMD_SAMPLE, 10'd74, 24'sd0);
    send_beat(CMD_TICK, 10'd0, 24'sd0);
    send_beat(CMD_STATUS, 10'h3FF, 24'shFF_FFFF);
    send_beat(CMD_ADJUST, 10'd0, 24'sd0);
    stop_input();
    drain();

    // widest band, zero turning, default period, zero ticks per second
    calm = 1'b1;
    program_regs(10'd1023, 10'd0, 24'd0, 24'd0, 5'd0, 16'd0);
    send_random(30, 5);
    stop_input();
    drain();

    // inverted band, always turning, longest dead time, prescaler run up high
    calm = 1'b0;
    program_regs(10'd0, 10'd1023, 24'hFF_FFFF, 24'd1, 5'd30, 16'hFFFF);
    send_random(30, 5);
    repeat (28) send_beat(CMD_TICK, TEMP_W'($urandom), 24'($urandom));
    stop_input();
    drain();

    // lower the prescaler limit, long receiver hold, then a full pause mid-phase
    program_regs(10'd600, 10'd400, 24'd3, 24'd7, 5'd3, 16'd2);
    hold_request = 1'b1;
    repeat (3) send_beat(CMD_TICK, TEMP_W'($urandom), 24'($urandom));
    send_random(25, 10);
    stop_input();
    drain();
    send_random(35, 10);
    stop_input();
    drain();

    repeat (3) begin
      program_random();
      calm = ($urandom_range(0, 3) == 0);
      send_random(65, 20);
      stop_input();
      drain();
    end

    // large offsets both ways with a one-tick second
    calm = 1'b0;
    program_regs(TEMP_W'($urandom), TEMP_W'($urandom), 24'($urandom), 24'hFF_FFFF, 5'd1,
                 16'd0);
    repeat (6) send_beat(CMD_TICK, TEMP_W'($urandom), 24'($urandom));
    send_random(30, 8388607);
    stop_input();
    drain();

    // final stretch without idling on either side
    calm = 1'b1;
    program_regs(10'd500, 10'd480, 24'd4, 24'd9, 5'd2, 16'd3);
    send_random(40, 10);
    stop_input();
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("covered %0d ticks, %0d samples, %0d adjustments, %0d status reads, %0d settings",
             sb.cmd_count[CMD_TICK], sb.cmd_count[CMD_SAMPLE], sb.cmd_count[CMD_ADJUST],
             sb.cmd_count[CMD_STATUS], settings);
    $display("%0d beats checked, %0d with the seconds counter at its top", sb.checked,
             sb.top_hits);
    if (sb.errors == 0) begin
      $display("[incubator_heater_and_turner_control_unit] OK");
    end else begin
      $display("[incubator_heater_and_turner_control_unit] ERROR");
    end
    $finish;
  end

endmodule
